// ===== hw/rtl/temperature_display_formatter_top_defines.svh =====
// assertion macros for the temperature display formatter
`ifndef TEMPERATURE_DISPLAY_FORMATTER_TOP_DEFINES_SVH
`define TEMPERATURE_DISPLAY_FORMATTER_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define TDF_ASSERT_NOW(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define TDF_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/tdf_pkg.sv =====
package tdf_pkg;

	// display mode kept across items
	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_CEL  = 2'd1,
		MODE_FAH  = 2'd2,
		MODE_BOTH = 2'd3
	} mode_t;

	// display position codes
	localparam logic [4:0] BLANK_CODE = 5'd16;
	localparam logic [4:0] CEL_CODE   = 5'd12;
	localparam logic [4:0] FAH_CODE   = 5'd15;

	// decimal point patterns
	localparam logic [7:0] POINT_NONE   = 8'h00;
	localparam logic [7:0] POINT_SINGLE = 8'h40;
	localparam logic [7:0] POINT_DUAL   = 8'h44;

	// temperature times 100, wide enough for fahrenheit
	localparam int VAL_W = 17;

	// fahrenheit offset, 32 degrees times 100
	localparam logic [VAL_W-1:0] FAH_OFFSET = 17'd3200;

	// decimal digits of one temperature, saturation flag for tens
	typedef struct packed {
		logic       sat;
		logic [3:0] tens;
		logic [3:0] ones;
		logic [3:0] tenths;
		logic [3:0] hund;
	} digits_t;

	// v / 10 by reciprocal multiply, exact for v below 2^22
	function automatic logic [13:0] div10(input logic [VAL_W-1:0] v);
		logic [37:0] p;
		p = 38'(v) * 38'(20'd838861);
		return p[36:23];
	endfunction

	// v / 100 by reciprocal multiply, exact for v below 2^20
	function automatic logic [9:0] div100(input logic [VAL_W-1:0] v);
		logic [37:0] p;
		p = 38'(v) * 38'(20'd671089);
		return p[35:26];
	endfunction

	// v / 1000 by reciprocal multiply, exact for v below 2^22
	function automatic logic [6:0] div1000(input logic [VAL_W-1:0] v);
		logic [37:0] p;
		p = 38'(v) * 38'(21'd1073742);
		return p[36:30];
	endfunction

endpackage

// ===== hw/rtl/temperature_display_formatter_top.sv =====
// temperature display formatter
// slave channel s_*: one transfer per sensor reading, tdata carries the two
// sensor register bytes and the four debounced button levels
// master channel m_*: one transfer per reading, tdata carries the eight
// display position codes and the decimal point mask, tuser the overflow flag
// the buttons update the kept display mode, which applies to the same reading
// a result is offered on m_tvalid once it has passed from the input register, loaded at
// the transfer edge, into the result register, which loads when it is empty or taken
// throughput: one reading per cycle while the master accepts, set by the single
// combinational pass of constant multiplies and digit splits between the two registers
// a stalled master holds its result; the input register still takes one more
// reading, and s_tready drops only when both registers are full
// reset clears both valid flags and returns the mode to off (all blank)
`include "temperature_display_formatter_top_defines.svh"

module temperature_display_formatter_top
	import tdf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // temp_high[7:0], temp_low[15:8], buttons[19:16], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // digit_0[4:0] .. digit_7[39:35], point_mask[47:40]
	output logic [0:0]  m_tuser   // overflow[0]
);

	logic             valid_s1;
	logic [7:0]       temp_high_s1;
	logic [7:0]       temp_low_s1;
	mode_t            mode_s1;
	logic             valid_s2;
	logic [7:0][4:0]  digit_s2;
	logic [7:0]       point_mask_s2;
	logic             overflow_s2;

	logic             in_xfer;
	logic             adv_s2;
	mode_t            mode_next;
	logic [12:0]      reading;
	logic [VAL_W-1:0] cel_x100;
	logic [VAL_W-1:0] fah_x100;
	digits_t          cel_dig;
	digits_t          fah_dig;
	logic [7:0][4:0]  digit_d;
	logic [7:0]       point_mask_d;
	logic             overflow_d;

	// pipeline handshake
	assign adv_s2   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;
	assign in_xfer  = s_tvalid && s_tready;

	// mode update from the buttons of each transfer
	tdf_mode u_mode (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_xfer),
		.buttons   (s_tdata[19:16]),
		.mode_next (mode_next)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			temp_high_s1 <= s_tdata[7:0];
			temp_low_s1  <= s_tdata[15:8];
			mode_s1      <= mode_next;
		end
	end

	// 13-bit reading and both scales times 100
	assign reading  = {temp_high_s1, temp_low_s1[7:3]};
	assign cel_x100 = VAL_W'((19'(reading) * 19'd25) >> 2);
	assign fah_x100 = VAL_W'((19'(reading) * 19'd45) >> 2) + FAH_OFFSET;

	tdf_split u_split_cel (
		.value  (cel_x100),
		.digits (cel_dig)
	);

	tdf_split u_split_fah (
		.value  (fah_x100),
		.digits (fah_dig)
	);

	// digit layout and decimal points by mode
	always_comb begin
		digit_d      = {8{BLANK_CODE}};
		point_mask_d = POINT_NONE;
		overflow_d   = 1'b0;
		case (mode_s1)
			MODE_CEL: begin
				digit_d[3]   = CEL_CODE;
				digit_d[4]   = {1'b0, cel_dig.hund};
				digit_d[5]   = {1'b0, cel_dig.tenths};
				digit_d[6]   = {1'b0, cel_dig.ones};
				digit_d[7]   = {1'b0, cel_dig.tens};
				point_mask_d = POINT_SINGLE;
				overflow_d   = cel_dig.sat;
			end
			MODE_FAH: begin
				digit_d[3]   = FAH_CODE;
				digit_d[4]   = {1'b0, fah_dig.hund};
				digit_d[5]   = {1'b0, fah_dig.tenths};
				digit_d[6]   = {1'b0, fah_dig.ones};
				digit_d[7]   = {1'b0, fah_dig.tens};
				point_mask_d = POINT_SINGLE;
				overflow_d   = fah_dig.sat;
			end
			MODE_BOTH: begin
				digit_d[0]   = {1'b0, cel_dig.hund};
				digit_d[1]   = {1'b0, cel_dig.tenths};
				digit_d[2]   = {1'b0, cel_dig.ones};
				digit_d[3]   = {1'b0, cel_dig.tens};
				digit_d[4]   = {1'b0, fah_dig.hund};
				digit_d[5]   = {1'b0, fah_dig.tenths};
				digit_d[6]   = {1'b0, fah_dig.ones};
				digit_d[7]   = {1'b0, fah_dig.tens};
				point_mask_d = POINT_DUAL;
				overflow_d   = cel_dig.sat | fah_dig.sat;
			end
			default: begin
				digit_d      = {8{BLANK_CODE}};
				point_mask_d = POINT_NONE;
				overflow_d   = 1'b0;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			digit_s2      <= digit_d;
			point_mask_s2 <= point_mask_d;
			overflow_s2   <= overflow_d;
		end
	end

	// master side
	assign m_tvalid = valid_s2;
	assign m_tdata  = {point_mask_s2, digit_s2};
	assign m_tuser  = overflow_s2;

	// display off shows all blanks and never flags overflow
	`TDF_ASSERT_NOW(a_off_blank, valid_s2 && point_mask_s2 == POINT_NONE, !overflow_s2 && digit_s2 == {8{BLANK_CODE}}, "display off with digits or overflow")

	// single-scale layouts carry the unit letter in position three
	`TDF_ASSERT_NOW(a_unit_letter, valid_s2 && point_mask_s2 == POINT_SINGLE, digit_s2[3] == CEL_CODE || digit_s2[3] == FAH_CODE, "unit letter missing")

	// a waiting input item moves into an empty result register
	`TDF_ASSERT_NEXT(a_advance, valid_s1 && !valid_s2, valid_s2, "pipeline failed to advance")

endmodule

// ===== hw/rtl/tdf_mode.sv =====
module tdf_mode
	import tdf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  logic [3:0] buttons,
	output mode_t      mode_next
);

	mode_t mode_q;

	// button priority: 0, then 2, then 3, then 1; none keeps the mode
	always_comb begin
		if (buttons[0]) begin
			mode_next = MODE_CEL;
		end else if (buttons[2]) begin
			mode_next = MODE_FAH;
		end else if (buttons[3]) begin
			mode_next = MODE_BOTH;
		end else if (buttons[1]) begin
			mode_next = MODE_OFF;
		end else begin
			mode_next = mode_q;
		end
	end

	// mode register, updated on each accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OFF;
		end else if (load) begin
			mode_q <= mode_next;
		end
	end

endmodule

// ===== hw/rtl/tdf_split.sv =====
module tdf_split
	import tdf_pkg::*;
(
	input  logic [VAL_W-1:0] value,
	output digits_t          digits
);

	logic [13:0] q10;
	logic [9:0]  q100;
	logic [6:0]  q1000;
	logic [13:0] rem1;
	logic [13:0] rem10;
	logic [9:0]  rem100;

	// quotients by ten, hundred and thousand in parallel
	assign q10   = div10(value);
	assign q100  = div100(value);
	assign q1000 = div1000(value);

	// each digit is a quotient less ten times the next one
	assign rem1   = value[13:0] - 14'(q10 * 14'd10);
	assign rem10  = q10 - 14'(q100 * 14'd10);
	assign rem100 = q100 - 10'(q1000 * 10'd10);

	// tens saturates at nine
	always_comb begin
		digits.hund   = rem1[3:0];
		digits.tenths = rem10[3:0];
		digits.ones   = rem100[3:0];
		if (q1000 > 7'd9) begin
			digits.tens = 4'd9;
			digits.sat  = 1'b1;
		end else begin
			digits.tens = q1000[3:0];
			digits.sat  = 1'b0;
		end
	end

endmodule

// ===== sim/temperature_display_formatter_top_tb.sv =====
`timescale 1ns / 1ps

module temperature_display_formatter_top_tb;
	import tdf_pkg::*;

	// button levels, one bit per button
	localparam logic [3:0] BTN_NONE = 4'b0000;
	localparam logic [3:0] BTN_CEL  = 4'b0001;
	localparam logic [3:0] BTN_OFF  = 4'b0010;
	localparam logic [3:0] BTN_FAH  = 4'b0100;
	localparam logic [3:0] BTN_BOTH = 4'b1000;

	localparam int RANDOM_READINGS = 1525;
	localparam int QUIET_FROM      = 600;
	localparam int QUIET_TO        = 1200;

	// one sensor reading with button levels; hold marks a wait for all results
	typedef struct packed {
		logic       hold;
		logic [3:0] btn;
		logic [7:0] lo;
		logic [7:0] hi;
	} reading_t;

	// one display frame, position 0 in the lowest bits
	typedef struct packed {
		logic            ovf;
		logic [7:0]      points;
		logic [7:0][4:0] pos;
	} frame_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;  // temp_high[7:0], temp_low[15:8], buttons[19:16], zero pad
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;       // digit_0[4:0] .. digit_7[39:35], point_mask[47:40]
	logic [0:0]  m_tuser;       // overflow[0]

	reading_t readings_q[$];
	frame_t   frames_q[$];
	mode_t    shown_mode = MODE_OFF;
	logic     awaiting = 1'b0;
	int       cyc = 0;
	int       bad_results = 0;

	temperature_display_formatter_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// mode after the buttons of one reading, priority bit 0, then 2, then 3, then 1
	function automatic mode_t next_mode(input mode_t m, input logic [3:0] b);
		if (b[0]) begin
			return MODE_CEL;
		end else if (b[2]) begin
			return MODE_FAH;
		end else if (b[3]) begin
			return MODE_BOTH;
		end else if (b[1]) begin
			return MODE_OFF;
		end
		return m;
	endfunction

	// hundredths, tenths, ones, tens of a value scaled by 100
	function automatic void split_decimal(input int unsigned v, output logic [3:0][3:0] d,
			output logic sat);
		int unsigned tens;
		tens = v / 1000;
		sat = (tens > 9);
		d[0] = 4'(v % 10);
		d[1] = 4'((v / 10) % 10);
		d[2] = 4'((v / 100) % 10);
		d[3] = sat ? 4'd9 : 4'(tens);
	endfunction

	// frame shown for one sensor word in a given mode
	function automatic frame_t format_reading(input logic [15:0] word, input mode_t m);
		int unsigned     n;
		int unsigned     cel;
		int unsigned     fah;
		logic [3:0][3:0] cd;
		logic [3:0][3:0] fd;
		logic            csat;
		logic            fsat;
		frame_t          f;
		n = word >> 3;
		cel = (n * 25) / 4;
		fah = (n * 45) / 4 + 3200;
		split_decimal(cel, cd, csat);
		split_decimal(fah, fd, fsat);
		for (int i = 0; i < 8; i++) f.pos[i] = BLANK_CODE;
		f.points = POINT_NONE;
		f.ovf = 1'b0;
		case (m)
			MODE_CEL: begin
				f.pos[3] = CEL_CODE;
				for (int i = 0; i < 4; i++) f.pos[4 + i] = 5'(cd[i]);
				f.points = POINT_SINGLE;
				f.ovf = csat;
			end
			MODE_FAH: begin
				f.pos[3] = FAH_CODE;
				for (int i = 0; i < 4; i++) f.pos[4 + i] = 5'(fd[i]);
				f.points = POINT_SINGLE;
				f.ovf = fsat;
			end
			MODE_BOTH: begin
				for (int i = 0; i < 4; i++) begin
					f.pos[i] = 5'(cd[i]);
					f.pos[4 + i] = 5'(fd[i]);
				end
				f.points = POINT_DUAL;
				f.ovf = csat | fsat;
			end
			default: ;
		endcase
		return f;
	endfunction

	function automatic string frame_text(input frame_t f);
		return $sformatf("pos7..0 %0d %0d %0d %0d %0d %0d %0d %0d points %02h ovf %0d",
			f.pos[7], f.pos[6], f.pos[5], f.pos[4], f.pos[3], f.pos[2], f.pos[1], f.pos[0],
			f.points, f.ovf);
	endfunction

	function automatic logic quiet_now();
		return cyc >= QUIET_FROM && cyc < QUIET_TO;
	endfunction

	task automatic add_reading(input logic [15:0] word, input logic [3:0] btn,
			input logic hold = 1'b0);
		reading_t r;
		r.hold = hold;
		r.btn = btn;
		r.hi = word[15:8];
		r.lo = word[7:0];
		readings_q.push_back(r);
	endtask

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	// sender: next reading from the queue, random gaps outside the quiet window
	always @(posedge clk or negedge arst_n) begin : drive
		reading_t r;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (readings_q.size() != 0 && (quiet_now() || $urandom_range(99) >= 10)
					&& !(readings_q[0].hold && (awaiting || s_tvalid))) begin
				r = readings_q.pop_front();
				s_tdata <= {4'b0000, r.btn, r.lo, r.hi};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet_now() || $urandom_range(99) >= 10;
		end
	end

	// check each result transfer, then predict from each input transfer
	always @(posedge clk or negedge arst_n) begin : watch
		frame_t got;
		frame_t want;
		if (!arst_n) begin
			shown_mode = MODE_OFF;
			awaiting <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tuser[0], m_tdata};
				if (frames_q.size() == 0) begin
					if (bad_results < 10)
						$display("unexpected result: %s", frame_text(got));
					bad_results++;
				end else begin
					want = frames_q.pop_front();
					if (got.pos != want.pos || got.points != want.points
							|| got.ovf != want.ovf) begin
						if (bad_results < 10) begin
							$display("mismatch expected: %s", frame_text(want));
							$display("mismatch actual:   %s", frame_text(got));
						end
						bad_results++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				shown_mode = next_mode(shown_mode, s_tdata[19:16]);
				frames_q.push_back(format_reading({s_tdata[7:0], s_tdata[15:8]}, shown_mode));
			end
			awaiting <= frames_q.size() != 0;
		end
	end

	initial begin
		logic [15:0] word;
		logic [3:0]  btn;

		// off after reset, then off by button with a saturating reading
		add_reading(16'h0000, BTN_NONE);
		add_reading(16'hFFFF, BTN_OFF);
		// celsius, zero and the tens saturation edge
		add_reading(16'h0000, BTN_CEL);
		add_reading(16'hFFFF, BTN_NONE);
		add_reading(16'h31FF, BTN_NONE);
		add_reading(16'h3200, BTN_NONE);
		add_reading(16'h0008, BTN_NONE);
		// fahrenheit saturation not shown in celsius mode
		add_reading(16'h12E8, BTN_NONE);
		// fahrenheit, offset and its saturation edge
		add_reading(16'h0000, BTN_FAH);
		add_reading(16'h12E7, BTN_NONE);
		add_reading(16'h12E8, BTN_NONE);
		// both scales
		add_reading(16'h12E0, BTN_BOTH);
		add_reading(16'h12E8, BTN_NONE);
		add_reading(16'h31F8, BTN_NONE);
		add_reading(16'h3200, BTN_NONE);
		add_reading(16'h8000, BTN_NONE);
		add_reading(16'h0007, BTN_NONE);
		// button priority combinations
		add_reading(16'h0C80, BTN_CEL | BTN_OFF | BTN_FAH | BTN_BOTH);
		add_reading(16'h0C80, BTN_OFF | BTN_FAH | BTN_BOTH);
		add_reading(16'h0C80, BTN_OFF | BTN_BOTH);
		add_reading(16'h0C80, BTN_OFF | BTN_FAH);
		add_reading(16'h3200, BTN_OFF);
		add_reading(16'h5555, BTN_CEL | BTN_OFF);
		add_reading(16'hAAAA, BTN_FAH | BTN_BOTH);

		// mostly held buttons so modes persist, words full range or near room range
		for (int i = 0; i < RANDOM_READINGS; i++) begin
			if ($urandom_range(99) < 50)
				word = 16'($urandom_range(16'hFFFF));
			else
				word = {13'($urandom_range(1700)), 3'($urandom_range(7))};
			btn = ($urandom_range(99) < 80) ? BTN_NONE : 4'($urandom_range(15));
			add_reading(word, btn, i % 400 == 0);
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do @(negedge clk); while (readings_q.size() != 0 || s_tvalid || awaiting);
		repeat (10) @(negedge clk);

		if (bad_results == 0 && frames_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// run limit
	initial begin
		#400000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tdf_pkg.sv
hw/rtl/tdf_mode.sv
hw/rtl/tdf_split.sv
hw/rtl/temperature_display_formatter_top.sv
sim/temperature_display_formatter_top_tb.sv
